// ===== src/dvtu_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package dvtu_pkg;

  // Field widths
  localparam int SLOT_W   = 3;
  localparam int SLOT_SPAN = 2 ** SLOT_W;
  localparam int IP_W     = 32;
  localparam int HALF_W   = 16;
  localparam int COST_W   = 16;
  localparam int SUM_W    = COST_W + 1;

  // Stream widths
  localparam int IN_USER_W  = 3;
  localparam int IN_DATA_W  = 152;
  localparam int OUT_DATA_W = 104;
  localparam int OUT_PAD_W  = 5;

  // Operation codes carried on in_tuser
  typedef enum logic [IN_USER_W-1:0] {
    OP_LOAD_ROUTE = 3'd0,
    OP_LOAD_FWD   = 3'd1,
    OP_UPD_HDR    = 3'd2,
    OP_UPD_ENTRY  = 3'd3,
    OP_READ_FWD   = 3'd4
  } op_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_SENDER = 2'd1,
    ST_EMPTY     = 2'd2
  } status_t;

  typedef struct packed {
    logic [IP_W-1:0]   ip;
    logic [HALF_W-1:0] port;
    logic [HALF_W-1:0] id;
    logic [COST_W-1:0] cost;
  } route_ent_t;

  typedef struct packed {
    logic [HALF_W-1:0] dest_id;
    logic [HALF_W-1:0] hop_id;
    logic [COST_W-1:0] cost;
    logic [HALF_W-1:0] hop_port;
    logic [IP_W-1:0]   hop_ip;
  } fwd_ent_t;

  typedef struct packed {
    status_t           status;
    logic              improved;
    logic [HALF_W-1:0] dest_id;
    logic [HALF_W-1:0] hop_id;
    logic [COST_W-1:0] cost;
    logic [HALF_W-1:0] hop_port;
    logic [IP_W-1:0]   hop_ip;
  } res_t;

  // Handshake between the engine and the output stage
  typedef struct packed {
    logic valid;
    res_t res;
  } res_push_t;

endpackage

`default_nettype wire

// ===== src/dvtu_out_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dvtu_out_stage
  import dvtu_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire res_push_t             push,
  output logic                       push_ready,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // status[1:0], improved[2], out_dest_id[18:3], out_hop_id[34:19],
  // out_cost[50:35], out_hop_port[66:51], out_hop_ip[98:67], zero[103:99]
  output logic [OUT_DATA_W-1:0]      out_tdata
);

  logic out_valid_r;
  logic out_valid_nxt;
  res_t res_r;

  // Take a new word when the register is empty or being drained
  assign push_ready = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (push_ready) begin
      out_valid_nxt = push.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold the word until it is taken
  always_ff @(posedge clk) begin
    if (push.valid && push_ready) begin
      res_r <= push.res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{OUT_PAD_W{1'b0}}, res_r.hop_ip, res_r.hop_port, res_r.cost,
                       res_r.hop_id, res_r.dest_id, res_r.improved, res_r.status};

endmodule

`default_nettype wire

// ===== src/distance_vector_table_update.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Distance-vector route table engine. Route entries (ip, port, id, cost) and
// forwarding entries (destination, next hop id, cost, next hop port, next hop
// ip) live in two single-port-write synchronous memories; valid bits are flops
// cleared by reset, so no clearing pass is needed. The operation code rides on
// in_tuser and every word yields exactly one result word. Items are handled one
// at a time: a load or an unknown operation goes straight to the result, a read
// passes through a read state, an update header scans the route table, and an
// update entry scans the route table and, when a route improved, the forwarding
// table too. Each scan covers SCAN_N entries, the smaller of TABLE_DEPTH and 8,
// one entry per cycle over the memory read port; a full output register
// holds the finished item until the word ahead of it is taken.
// A finished result waits in an output register while the next word is taken.
module distance_vector_table_update
  import dvtu_pkg::*;
#(
  parameter int TABLE_DEPTH = 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // slot[2:0], entry_ip[34:3], entry_port[50:35], entry_id[66:51],
  // entry_cost[82:67], hop_id[98:83], hop_port[114:99], hop_ip[146:115],
  // zero[151:147]
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  // operation[2:0]
  input  wire logic [IN_USER_W-1:0]  in_tuser,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // status[1:0], improved[2], out_dest_id[18:3], out_hop_id[34:19],
  // out_cost[50:35], out_hop_port[66:51], out_hop_ip[98:67], zero[103:99]
  output logic [OUT_DATA_W-1:0]      out_tdata
);

  localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int SCAN_N = (TABLE_DEPTH < SLOT_SPAN) ? TABLE_DEPTH : SLOT_SPAN;
  localparam int CNT_W  = $clog2(SCAN_N + 1);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_READ  = 6'b000010,
    S_HSCAN = 6'b000100,
    S_RSCAN = 6'b001000,
    S_FSCAN = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  // Unpack the input word
  logic [SLOT_W-1:0] in_slot;
  logic [IP_W-1:0]   in_entry_ip;
  logic [HALF_W-1:0] in_entry_port;
  logic [HALF_W-1:0] in_entry_id;
  logic [COST_W-1:0] in_entry_cost;
  logic [HALF_W-1:0] in_hop_id;
  logic [HALF_W-1:0] in_hop_port;
  logic [IP_W-1:0]   in_hop_ip;

  assign in_slot       = in_tdata[2:0];
  assign in_entry_ip   = in_tdata[34:3];
  assign in_entry_port = in_tdata[50:35];
  assign in_entry_id   = in_tdata[66:51];
  assign in_entry_cost = in_tdata[82:67];
  assign in_hop_id     = in_tdata[98:83];
  assign in_hop_port   = in_tdata[114:99];
  assign in_hop_ip     = in_tdata[146:115];

  logic [31:0]      slot_ext;
  logic [IDX_W-1:0] slot_idx;
  logic             slot_in_range;
  logic             in_fire;

  assign slot_ext      = 32'(in_slot);
  assign slot_idx      = slot_ext[IDX_W-1:0];
  assign slot_in_range = slot_ext < 32'(TABLE_DEPTH);
  assign in_fire       = in_tvalid && in_tready;

  // Control and working registers
  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              chk_v_r, chk_v_nxt;
  logic [IDX_W-1:0]  chk_idx_r, chk_idx_nxt;
  logic              found_r, found_nxt;
  logic              imp_r, imp_nxt;
  logic              rd_ok_r, rd_ok_nxt;
  logic [IP_W-1:0]   key_ip_r, key_ip_nxt;
  logic [HALF_W-1:0] dest_r, dest_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [COST_W-1:0] snd_cost_r, snd_cost_nxt;
  logic [HALF_W-1:0] snd_id_r, snd_id_nxt;
  logic [HALF_W-1:0] snd_port_r, snd_port_nxt;
  logic [IP_W-1:0]   snd_ip_r, snd_ip_nxt;
  res_t              res_r, res_nxt;
  logic [TABLE_DEPTH-1:0] route_valid_r, route_valid_nxt;
  logic [TABLE_DEPTH-1:0] fwd_valid_r, fwd_valid_nxt;

  // Memory ports
  route_ent_t        route_mem_r [TABLE_DEPTH];
  fwd_ent_t          fwd_mem_r [TABLE_DEPTH];
  route_ent_t        route_rdata_r;
  fwd_ent_t          fwd_rdata_r;
  logic              route_we;
  logic [IDX_W-1:0]  route_waddr;
  route_ent_t        route_wdata;
  logic              fwd_we;
  logic [IDX_W-1:0]  fwd_waddr;
  fwd_ent_t          fwd_wdata;
  logic [IDX_W-1:0]  fwd_raddr;

  logic [31:0]       cnt_ext;
  logic [IDX_W-1:0]  scan_idx;
  logic              scan_issue;
  logic              scan_done;

  res_push_t         push;
  logic              push_ready;

  assign cnt_ext    = 32'(cnt_r);
  assign scan_idx   = cnt_ext[IDX_W-1:0];
  assign scan_issue = cnt_r != CNT_W'(SCAN_N);
  assign scan_done  = !scan_issue && !chk_v_r;
  assign fwd_raddr  = (state_r == S_IDLE) ? slot_idx : scan_idx;
  assign in_tready  = state_r == S_IDLE;

  assign push.valid = state_r == S_DONE;
  assign push.res   = res_r;

  // Sequence one item through its read or scan states
  always_comb begin
    state_nxt       = state_r;
    cnt_nxt         = cnt_r;
    chk_v_nxt       = 1'b0;
    chk_idx_nxt     = chk_idx_r;
    found_nxt       = found_r;
    imp_nxt         = imp_r;
    rd_ok_nxt       = rd_ok_r;
    key_ip_nxt      = key_ip_r;
    dest_nxt        = dest_r;
    sum_nxt         = sum_r;
    snd_cost_nxt    = snd_cost_r;
    snd_id_nxt      = snd_id_r;
    snd_port_nxt    = snd_port_r;
    snd_ip_nxt      = snd_ip_r;
    res_nxt         = res_r;
    route_valid_nxt = route_valid_r;
    fwd_valid_nxt   = fwd_valid_r;
    route_we        = 1'b0;
    route_waddr     = chk_idx_r;
    route_wdata     = route_rdata_r;
    fwd_we          = 1'b0;
    fwd_waddr       = chk_idx_r;
    fwd_wdata       = fwd_rdata_r;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          res_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = S_DONE;
          case (in_tuser)
            OP_LOAD_ROUTE: begin
              if (slot_in_range) begin
                route_we                  = 1'b1;
                route_waddr               = slot_idx;
                route_wdata               = '{ip: in_entry_ip, port: in_entry_port,
                                              id: in_entry_id, cost: in_entry_cost};
                route_valid_nxt[slot_idx] = 1'b1;
              end
            end
            OP_LOAD_FWD: begin
              if (slot_in_range) begin
                fwd_we                  = 1'b1;
                fwd_waddr               = slot_idx;
                fwd_wdata               = '{dest_id: in_entry_id, hop_id: in_hop_id,
                                            cost: in_entry_cost, hop_port: in_hop_port,
                                            hop_ip: in_hop_ip};
                fwd_valid_nxt[slot_idx] = 1'b1;
              end
            end
            OP_UPD_HDR: begin
              found_nxt    = 1'b0;
              key_ip_nxt   = in_entry_ip;
              snd_cost_nxt = '0;
              snd_id_nxt   = '0;
              snd_port_nxt = '0;
              snd_ip_nxt   = '0;
              state_nxt    = S_HSCAN;
            end
            OP_UPD_ENTRY: begin
              imp_nxt   = 1'b0;
              dest_nxt  = in_entry_id;
              sum_nxt   = SUM_W'(snd_cost_r) + SUM_W'(in_entry_cost);
              state_nxt = S_RSCAN;
            end
            OP_READ_FWD: begin
              rd_ok_nxt = slot_in_range && fwd_valid_r[slot_idx];
              state_nxt = S_READ;
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      S_READ: begin
        if (rd_ok_r) begin
          res_nxt.dest_id  = fwd_rdata_r.dest_id;
          res_nxt.hop_id   = fwd_rdata_r.hop_id;
          res_nxt.cost     = fwd_rdata_r.cost;
          res_nxt.hop_port = fwd_rdata_r.hop_port;
          res_nxt.hop_ip   = fwd_rdata_r.hop_ip;
        end else begin
          res_nxt.status = ST_EMPTY;
        end
        state_nxt = S_DONE;
      end

      S_HSCAN: begin
        if (scan_issue) begin
          cnt_nxt     = cnt_r + 1'b1;
          chk_v_nxt   = 1'b1;
          chk_idx_nxt = scan_idx;
        end
        // Later slots overwrite earlier matches
        if (chk_v_r && route_valid_r[chk_idx_r] && route_rdata_r.ip == key_ip_r) begin
          found_nxt    = 1'b1;
          snd_cost_nxt = route_rdata_r.cost;
          snd_id_nxt   = route_rdata_r.id;
          snd_port_nxt = route_rdata_r.port;
          snd_ip_nxt   = route_rdata_r.ip;
        end
        if (scan_done) begin
          res_nxt.status = found_r ? ST_OK : ST_NO_SENDER;
          state_nxt      = S_DONE;
        end
      end

      S_RSCAN: begin
        if (scan_issue) begin
          cnt_nxt     = cnt_r + 1'b1;
          chk_v_nxt   = 1'b1;
          chk_idx_nxt = scan_idx;
        end
        // Relax a matching route and write its lower cost back
        if (chk_v_r && route_valid_r[chk_idx_r] && route_rdata_r.id == dest_r &&
            SUM_W'(route_rdata_r.cost) > sum_r) begin
          route_we         = 1'b1;
          route_wdata.cost = sum_r[COST_W-1:0];
          imp_nxt          = 1'b1;
        end
        if (scan_done) begin
          cnt_nxt          = '0;
          res_nxt.improved = imp_r;
          state_nxt        = imp_r ? S_FSCAN : S_DONE;
        end
      end

      S_FSCAN: begin
        if (scan_issue) begin
          cnt_nxt     = cnt_r + 1'b1;
          chk_v_nxt   = 1'b1;
          chk_idx_nxt = scan_idx;
        end
        // Route matching forwarding entries through the sender
        if (chk_v_r && fwd_valid_r[chk_idx_r] && fwd_rdata_r.dest_id == dest_r) begin
          fwd_we             = 1'b1;
          fwd_wdata.hop_id   = snd_id_r;
          fwd_wdata.cost     = sum_r[COST_W-1:0];
          fwd_wdata.hop_port = snd_port_r;
          fwd_wdata.hop_ip   = snd_ip_r;
        end
        if (scan_done) begin
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        if (push_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      cnt_r         <= '0;
      chk_v_r       <= 1'b0;
      found_r       <= 1'b0;
      imp_r         <= 1'b0;
      rd_ok_r       <= 1'b0;
      route_valid_r <= '0;
      fwd_valid_r   <= '0;
      snd_cost_r    <= '0;
      snd_id_r      <= '0;
      snd_port_r    <= '0;
      snd_ip_r      <= '0;
    end else begin
      state_r       <= state_nxt;
      cnt_r         <= cnt_nxt;
      chk_v_r       <= chk_v_nxt;
      found_r       <= found_nxt;
      imp_r         <= imp_nxt;
      rd_ok_r       <= rd_ok_nxt;
      route_valid_r <= route_valid_nxt;
      fwd_valid_r   <= fwd_valid_nxt;
      snd_cost_r    <= snd_cost_nxt;
      snd_id_r      <= snd_id_nxt;
      snd_port_r    <= snd_port_nxt;
      snd_ip_r      <= snd_ip_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    chk_idx_r <= chk_idx_nxt;
    key_ip_r  <= key_ip_nxt;
    dest_r    <= dest_nxt;
    sum_r     <= sum_nxt;
    res_r     <= res_nxt;
  end

  // Route memory
  always_ff @(posedge clk) begin
    if (route_we) begin
      route_mem_r[route_waddr] <= route_wdata;
    end
    route_rdata_r <= route_mem_r[scan_idx];
  end

  // Forwarding memory
  always_ff @(posedge clk) begin
    if (fwd_we) begin
      fwd_mem_r[fwd_waddr] <= fwd_wdata;
    end
    fwd_rdata_r <= fwd_mem_r[fwd_raddr];
  end

  dvtu_out_stage u_out_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_ready (push_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // A pending compare only exists inside a scan
  a_chk_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    chk_v_r |-> (state_r == S_HSCAN) || (state_r == S_RSCAN) || (state_r == S_FSCAN))
    else $error("compare pending outside a scan");

  // Forwarding rewrite only follows an improvement
  a_fscan_imp: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FSCAN) |-> imp_r)
    else $error("forwarding scan without improvement");

  // Route memory is written only by a load or a relaxation
  a_route_we: assert property (@(posedge clk) disable iff (!rst_n)
    route_we |-> (state_r == S_RSCAN) || ((state_r == S_IDLE) && in_tvalid))
    else $error("unexpected route memory write");

  // A handed-off result shows up on the output
  a_push_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) && push_ready |=> (state_r == S_IDLE) && out_tvalid)
    else $error("result lost at output stage");

  // A header starts with no sender found
  a_hdr_clear: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (in_tuser == OP_UPD_HDR) |=> !found_r && (state_r == S_HSCAN))
    else $error("header scan did not start clean");

endmodule

`default_nettype wire

// ===== tb/tb_distance_vector_table_update.sv =====
`timescale 1ns / 1ps

module tb_distance_vector_table_update;
  import dvtu_pkg::*;

  localparam int TABLE_SLOTS = 8;
  localparam int IDLE_MAX    = 9;
  localparam int OP_CODE_MAX = 2 ** IN_USER_W - 1;
  localparam int DRAIN_TAIL  = 40;
  localparam int PRINT_CAP   = 50;

  // One input word, split into its fields
  typedef struct {
    logic [IN_USER_W-1:0] op;
    logic [SLOT_W-1:0]    slot;
    logic [IP_W-1:0]      ip;
    logic [HALF_W-1:0]    port;
    logic [HALF_W-1:0]    id;
    logic [COST_W-1:0]    cost;
    logic [HALF_W-1:0]    hop_id;
    logic [HALF_W-1:0]    hop_port;
    logic [IP_W-1:0]      hop_ip;
  } table_cmd_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic [IN_USER_W-1:0]  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;

  // Shadow copy of the tables and of the latched neighbour
  bit                rt_valid [TABLE_SLOTS];
  logic [IP_W-1:0]   rt_ip    [TABLE_SLOTS];
  logic [HALF_W-1:0] rt_port  [TABLE_SLOTS];
  logic [HALF_W-1:0] rt_id    [TABLE_SLOTS];
  logic [COST_W-1:0] rt_cost  [TABLE_SLOTS];
  bit                fw_valid [TABLE_SLOTS];
  logic [HALF_W-1:0] fw_dest  [TABLE_SLOTS];
  logic [HALF_W-1:0] fw_hop_id[TABLE_SLOTS];
  logic [COST_W-1:0] fw_cost  [TABLE_SLOTS];
  logic [HALF_W-1:0] fw_port  [TABLE_SLOTS];
  logic [IP_W-1:0]   fw_ip    [TABLE_SLOTS];
  logic [COST_W-1:0] nbr_cost = '0;
  logic [HALF_W-1:0] nbr_id   = '0;
  logic [HALF_W-1:0] nbr_port = '0;
  logic [IP_W-1:0]   nbr_ip   = '0;

  res_t pending_replies[$];
  int   mismatch_count  = 0;
  int   reply_index     = 0;
  int   send_gap_max    = IDLE_MAX;
  int   recv_gap_max    = IDLE_MAX;
  int   hold_off_cycles = 0;

  // Small pools so that lookups and relaxations hit often
  logic [IP_W-1:0]   ip_pool[4];
  logic [HALF_W-1:0] id_pool[4];

  distance_vector_table_update #(
    .TABLE_DEPTH(TABLE_SLOTS)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Apply one word to the shadow tables and return the reply it must produce
  function automatic res_t predict_reply(input table_cmd_t c);
    res_t             r;
    bit               found;
    logic [SUM_W-1:0] sum;
    r = '0;
    case (c.op)
      OP_LOAD_ROUTE: begin
        if (c.slot < TABLE_SLOTS) begin
          rt_valid[c.slot] = 1'b1;
          rt_ip[c.slot]    = c.ip;
          rt_port[c.slot]  = c.port;
          rt_id[c.slot]    = c.id;
          rt_cost[c.slot]  = c.cost;
        end
      end
      OP_LOAD_FWD: begin
        if (c.slot < TABLE_SLOTS) begin
          fw_valid[c.slot]  = 1'b1;
          fw_dest[c.slot]   = c.id;
          fw_hop_id[c.slot] = c.hop_id;
          fw_cost[c.slot]   = c.cost;
          fw_port[c.slot]   = c.hop_port;
          fw_ip[c.slot]     = c.hop_ip;
        end
      end
      OP_UPD_HDR: begin
        // Last matching slot wins; zeros when nothing matches
        found    = 1'b0;
        nbr_cost = '0;
        nbr_id   = '0;
        nbr_port = '0;
        nbr_ip   = '0;
        for (int i = 0; i < TABLE_SLOTS; i++) begin
          if (rt_valid[i] && rt_ip[i] == c.ip) begin
            found    = 1'b1;
            nbr_cost = rt_cost[i];
            nbr_id   = rt_id[i];
            nbr_port = rt_port[i];
            nbr_ip   = rt_ip[i];
          end
        end
        if (!found) begin
          r.status = ST_NO_SENDER;
        end
      end
      OP_UPD_ENTRY: begin
        // Compare at full width so the sum never wraps
        sum = {1'b0, nbr_cost} + {1'b0, c.cost};
        for (int i = 0; i < TABLE_SLOTS; i++) begin
          if (rt_valid[i] && rt_id[i] == c.id && {1'b0, rt_cost[i]} > sum) begin
            rt_cost[i] = sum[COST_W-1:0];
            r.improved = 1'b1;
            for (int f = 0; f < TABLE_SLOTS; f++) begin
              if (fw_valid[f] && fw_dest[f] == c.id) begin
                fw_hop_id[f] = nbr_id;
                fw_cost[f]   = rt_cost[i];
                fw_port[f]   = nbr_port;
                fw_ip[f]     = nbr_ip;
              end
            end
          end
        end
      end
      OP_READ_FWD: begin
        if (c.slot < TABLE_SLOTS && fw_valid[c.slot]) begin
          r.dest_id  = fw_dest[c.slot];
          r.hop_id   = fw_hop_id[c.slot];
          r.cost     = fw_cost[c.slot];
          r.hop_port = fw_port[c.slot];
          r.hop_ip   = fw_ip[c.slot];
        end else begin
          r.status = ST_EMPTY;
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  task automatic flag_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= PRINT_CAP) begin
      $display("%0t ns: reply %0d: %s", $time, reply_index, msg);
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
    if (got !== want) begin
      flag_mismatch($sformatf("%s got %h, expected %h", name, got, want));
    end
  endtask

  // Offer one word after a random gap, record its reply once it is taken
  task automatic push_cmd(input table_cmd_t c);
    int gap;
    gap = $urandom_range(0, send_gap_max);
    repeat (gap) @(negedge clk);
    in_tuser  = c.op;
    in_tdata  = {c.hop_ip, c.hop_port, c.hop_id, c.cost, c.id, c.port, c.ip, c.slot};
    in_tvalid = 1'b1;
    @(posedge clk);
    while (in_tready !== 1'b1) @(posedge clk);
    pending_replies.push_back(predict_reply(c));
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  function automatic table_cmd_t noise_cmd();
    table_cmd_t c;
    c.op       = IN_USER_W'($urandom_range(0, OP_CODE_MAX));
    c.slot     = SLOT_W'($urandom);
    c.ip       = $urandom;
    c.port     = HALF_W'($urandom);
    c.id       = HALF_W'($urandom);
    c.cost     = COST_W'($urandom);
    c.hop_id   = HALF_W'($urandom);
    c.hop_port = HALF_W'($urandom);
    c.hop_ip   = $urandom;
    return c;
  endfunction

  task automatic send_route(input int slot, input logic [IP_W-1:0] ip,
                            input logic [HALF_W-1:0] port, input logic [HALF_W-1:0] id,
                            input logic [COST_W-1:0] cost);
    table_cmd_t c;
    c      = noise_cmd();
    c.op   = OP_LOAD_ROUTE;
    c.slot = SLOT_W'(slot);
    c.ip   = ip;
    c.port = port;
    c.id   = id;
    c.cost = cost;
    push_cmd(c);
  endtask

  task automatic send_fwd(input int slot, input logic [HALF_W-1:0] dest,
                          input logic [COST_W-1:0] cost, input logic [HALF_W-1:0] hop_id,
                          input logic [HALF_W-1:0] hop_port, input logic [IP_W-1:0] hop_ip);
    table_cmd_t c;
    c          = noise_cmd();
    c.op       = OP_LOAD_FWD;
    c.slot     = SLOT_W'(slot);
    c.id       = dest;
    c.cost     = cost;
    c.hop_id   = hop_id;
    c.hop_port = hop_port;
    c.hop_ip   = hop_ip;
    push_cmd(c);
  endtask

  task automatic send_header(input logic [IP_W-1:0] ip);
    table_cmd_t c;
    c    = noise_cmd();
    c.op = OP_UPD_HDR;
    c.ip = ip;
    push_cmd(c);
  endtask

  task automatic send_entry(input logic [HALF_W-1:0] id, input logic [COST_W-1:0] cost);
    table_cmd_t c;
    c      = noise_cmd();
    c.op   = OP_UPD_ENTRY;
    c.id   = id;
    c.cost = cost;
    push_cmd(c);
  endtask

  task automatic send_read(input int slot);
    table_cmd_t c;
    c      = noise_cmd();
    c.op   = OP_READ_FWD;
    c.slot = SLOT_W'(slot);
    push_cmd(c);
  endtask

  task automatic wait_for_replies();
    while (pending_replies.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [IP_W-1:0] pick_ip();
    if ($urandom_range(0, 9) == 0) begin
      return $urandom;
    end
    return ip_pool[$urandom_range(0, 3)];
  endfunction

  function automatic logic [HALF_W-1:0] pick_id();
    if ($urandom_range(0, 9) == 0) begin
      return HALF_W'($urandom);
    end
    return id_pool[$urandom_range(0, 3)];
  endfunction

  // Empty tables: reads miss, the lookup fails, unused codes answer zero
  task automatic test_empty_tables();
    table_cmd_t c;
    send_read(0);
    send_read(TABLE_SLOTS - 1);
    send_header('0);
    send_entry('0, '0);
    for (int code = int'(OP_READ_FWD) + 1; code <= OP_CODE_MAX; code++) begin
      c    = noise_cmd();
      c.op = IN_USER_W'(code);
      push_cmd(c);
    end
  endtask

  // Field extremes, duplicate sender ip, sum that must not wrap, relaxation
  task automatic test_loads_and_relax();
    send_route(0, '1, '1, 16'h1234, '1);
    send_route(5, '1, '0, 16'hABCD, 16'h0001);
    send_route(7, '0, 16'h5555, '1, '0);
    send_route(2, 32'h0A00_0001, 16'hAAAA, 16'h1234, 16'h0100);
    send_route(1, 32'h0000_0001, 16'h0F0F, 16'h7777, '1);
    send_fwd(7, 16'h1234, '1, '1, '1, '1);
    send_fwd(0, 16'h1234, '0, '0, '0, '0);
    send_fwd(3, '1, 16'h00AA, 16'h0055, 16'h3C3C, 32'hDEAD_BEEF);
    // Neighbour cost at maximum: a sum past 16 bits must not improve anything
    send_header(32'h0000_0001);
    send_entry(16'h1234, 16'h0001);
    // Duplicate ip: the higher slot is the sender
    send_header('1);
    send_entry(16'h1234, 16'hFFFE);
    send_entry(16'h1234, 16'h00FD);
    send_read(7);
    send_read(0);
    send_header(32'h1234_5678);
    send_entry(16'hABCD, '0);
    send_entry(16'h1234, '0);
    send_read(7);
    send_read(3);
  endtask

  // One well-formed exchange with random content, plus a little noise
  task automatic run_random_round();
    int n;
    n = $urandom_range(0, 3);
    repeat (n) send_route($urandom_range(0, TABLE_SLOTS - 1), pick_ip(),
                          HALF_W'($urandom), pick_id(), COST_W'($urandom));
    n = $urandom_range(0, 2);
    repeat (n) send_fwd($urandom_range(0, TABLE_SLOTS - 1), pick_id(), COST_W'($urandom),
                        HALF_W'($urandom), HALF_W'($urandom), $urandom);
    send_header(($urandom_range(0, 4) == 0) ? $urandom : pick_ip());
    n = $urandom_range(1, 5);
    repeat (n) send_entry(pick_id(), ($urandom_range(0, 1) == 1) ?
                          COST_W'($urandom_range(0, 16'h0FFF)) : COST_W'($urandom));
    n = $urandom_range(0, 2);
    repeat (n) send_read($urandom_range(0, TABLE_SLOTS - 1));
    n = $urandom_range(0, 1);
    repeat (n) push_cmd(noise_cmd());
  endtask

  task automatic test_random_rounds(input int rounds);
    for (int k = 0; k < rounds; k++) begin
      if (k % 20 == 0) begin
        foreach (ip_pool[i]) ip_pool[i] = $urandom;
        foreach (id_pool[i]) id_pool[i] = HALF_W'($urandom);
      end
      run_random_round();
    end
  endtask

  // Receiver holds off while the sender keeps offering back to back
  task automatic test_backpressure();
    hold_off_cycles = 80;
    send_gap_max    = 0;
    repeat (3) run_random_round();
    send_gap_max    = IDLE_MAX;
  endtask

  task automatic test_streaming();
    send_gap_max = 0;
    recv_gap_max = 0;
    repeat (10) run_random_round();
    send_gap_max = IDLE_MAX;
    recv_gap_max = IDLE_MAX;
  endtask

  // Sender pauses until every reply is back, then goes on
  task automatic test_drain_pause();
    repeat (4) begin
      repeat (2) run_random_round();
      wait_for_replies();
    end
  endtask

  // Take result words with random stalls and compare against predictions
  initial begin : reply_checker
    int   stall;
    res_t got;
    res_t want;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_off_cycles > 0) begin
        out_tready = 1'b0;
        repeat (hold_off_cycles) @(negedge clk);
        hold_off_cycles = 0;
      end
      stall = $urandom_range(0, recv_gap_max);
      if (stall > 0) begin
        out_tready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready = 1'b1;
      do @(posedge clk); while (out_tvalid !== 1'b1);
      got.status   = status_t'(out_tdata[1:0]);
      got.improved = out_tdata[2];
      got.dest_id  = out_tdata[18:3];
      got.hop_id   = out_tdata[34:19];
      got.cost     = out_tdata[50:35];
      got.hop_port = out_tdata[66:51];
      got.hop_ip   = out_tdata[98:67];
      if (pending_replies.size() == 0) begin
        flag_mismatch("result word with no prediction pending");
      end else begin
        want = pending_replies.pop_front();
        check_field("status", got.status, want.status);
        check_field("improved", got.improved, want.improved);
        check_field("dest_id", got.dest_id, want.dest_id);
        check_field("hop_id", got.hop_id, want.hop_id);
        check_field("cost", got.cost, want.cost);
        check_field("hop_port", got.hop_port, want.hop_port);
        check_field("hop_ip", got.hop_ip, want.hop_ip);
      end
      reply_index++;
    end
  end

  initial begin : watchdog
    #10_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = '0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    test_empty_tables();
    test_loads_and_relax();
    test_random_rounds(60);
    test_backpressure();
    test_streaming();
    test_drain_pause();
    test_random_rounds(70);

    // Drain, then allow any stray word to show up
    wait_for_replies();
    repeat (DRAIN_TAIL) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
